// ===== rtl/core/ple_pkg.sv =====
// ple_pkg: shared codes and types for the positional list engine.
// Depends on nothing; every other file of the block but ple_ram imports it.
package ple_pkg;

   // Request command codes
   localparam logic [2:0] CMD_READ   = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_APPEND = 3'd2;
   localparam logic [2:0] CMD_DELETE = 3'd3;
   localparam logic [2:0] CMD_MODIFY = 3'd4;

   // Fixed field widths of the channel words
   localparam int unsigned CMD_BITS  = 3;
   localparam int unsigned POS_BITS  = 7;
   localparam int unsigned DATA_BITS = 32;
   localparam int unsigned LEN_BITS  = 7;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // One finished result word, handed from the sequencer to the output stage
   typedef struct packed {
      logic [DATA_BITS-1:0] read_data;
      logic [LEN_BITS-1:0]  length;
      status_type           status;
   } result_type;

endpackage

// ===== rtl/core/ple_if.sv =====
// ple_if: request and response channel interfaces (valid/ready plus payload).
// Depends on ple_pkg for the field widths.
interface ple_req_if import ple_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CMD_BITS-1:0]  command;
   logic [POS_BITS-1:0]  position;
   logic [DATA_BITS-1:0] element;

   modport source (output valid, output command, output position, output element,
                   input ready);
   modport sink   (input valid, input command, input position, input element,
                   output ready);
endinterface

interface ple_rsp_if import ple_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [DATA_BITS-1:0] read_data;
   logic [LEN_BITS-1:0]  length;
   status_type           status;

   modport source (output valid, output read_data, output length, output status,
                   input ready);
   modport sink   (input valid, input read_data, input length, input status,
                   output ready);
endinterface

// ===== rtl/core/ple_ram.sv =====
// ple_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing; contents are undefined until written.
module ple_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ple_ctrl.sv =====
// ple_ctrl: request sequencer; keeps the entry count and walks the entry RAM
// for read, insert, append, delete and modify. Depends on ple_pkg, ple_if.
module ple_ctrl import ple_pkg::*; #(
   parameter int unsigned DEPTH      = 64,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   ple_req_if.sink                  req_if,
   input  logic                     out_free,
   output logic                     done_valid,
   output result_type               done_result,
   output logic                     ram_we,
   output logic [$clog2(DEPTH)-1:0] ram_waddr,
   output logic [VALUE_BITS-1:0]    ram_wdata,
   output logic [$clog2(DEPTH)-1:0] ram_raddr,
   input  logic [VALUE_BITS-1:0]    ram_rdata
);

   localparam int unsigned AW   = $clog2(DEPTH);
   localparam int unsigned CNTW = $clog2(DEPTH + 1);
   localparam int unsigned CMPW = (CNTW > POS_BITS) ? CNTW : POS_BITS;
   localparam logic [CNTW-1:0] CNT_ONE  = CNTW'(1);
   localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);
   localparam logic [AW-1:0]   ADDR_ONE = AW'(1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_SHIFT = 5'b00100,
      S_PLACE = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNTW-1:0]       count_ff, count_in;
   logic                  up_ff, up_in;          // shift direction: insert moves up
   logic [AW-1:0]         pos_ff, pos_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [AW-1:0]         addr_ff, addr_in;      // address read in the previous cycle
   logic [DATA_BITS-1:0]  rd_ff, rd_in;
   status_type            status_ff, status_in;

   logic [CMPW-1:0]       pos_ext, cnt_ext, last_ext;
   logic [AW-1:0]         req_addr, cnt_addr, last_addr;
   logic [VALUE_BITS-1:0] req_val;
   logic                  is_full, is_empty;

   assign pos_ext   = CMPW'(req_if.position);
   assign cnt_ext   = CMPW'(count_ff);
   assign last_ext  = CMPW'(count_ff - CNT_ONE);
   assign req_addr  = AW'(req_if.position);
   assign cnt_addr  = AW'(count_ff);
   assign last_addr = AW'(count_ff - CNT_ONE);
   assign req_val   = VALUE_BITS'(req_if.element);
   assign is_full   = (count_ff == CNT_FULL);
   assign is_empty  = (count_ff == '0);

   assign req_if.ready = (state_ff == S_IDLE);

   // Sequencer next state and RAM port drive
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      up_in     = up_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      addr_in   = addr_ff;
      rd_in     = rd_ff;
      status_in = status_ff;
      ram_we    = 1'b0;
      ram_waddr = pos_ff;
      ram_wdata = val_ff;
      ram_raddr = addr_ff;
      done_valid = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               pos_in    = req_addr;
               val_in    = req_val;
               rd_in     = '0;
               status_in = ST_OK;
               state_in  = S_DONE;
               case (req_if.command)
                  CMD_READ: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else if (pos_ext >= cnt_ext) begin
                        status_in = ST_RANGE;
                     end else begin
                        ram_raddr = req_addr;
                        state_in  = S_READ;
                     end
                  end
                  CMD_INSERT: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else if (pos_ext > cnt_ext) begin
                        status_in = ST_RANGE;
                     end else if (pos_ext == cnt_ext) begin
                        // insert at the end: no entries to move
                        ram_we    = 1'b1;
                        ram_waddr = req_addr;
                        ram_wdata = req_val;
                        count_in  = count_ff + CNT_ONE;
                     end else begin
                        // move entries up, starting from the last one
                        ram_raddr = last_addr;
                        addr_in   = last_addr;
                        up_in     = 1'b1;
                        state_in  = S_SHIFT;
                     end
                  end
                  CMD_APPEND: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_addr;
                        ram_wdata = req_val;
                        count_in  = count_ff + CNT_ONE;
                     end
                  end
                  CMD_DELETE: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else if (pos_ext >= cnt_ext) begin
                        status_in = ST_RANGE;
                     end else if (pos_ext == last_ext) begin
                        count_in = count_ff - CNT_ONE;
                     end else begin
                        // move entries down, starting just above the gap
                        ram_raddr = req_addr + ADDR_ONE;
                        addr_in   = req_addr + ADDR_ONE;
                        up_in     = 1'b0;
                        state_in  = S_SHIFT;
                     end
                  end
                  CMD_MODIFY: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else if (pos_ext >= cnt_ext) begin
                        status_in = ST_RANGE;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = req_addr;
                        ram_wdata = req_val;
                     end
                  end
                  default: begin
                     status_in = ST_RANGE;
                  end
               endcase
            end
         end

         S_READ: begin
            rd_in    = DATA_BITS'(ram_rdata);
            state_in = S_DONE;
         end

         // one entry moved per cycle: write what was read, read the next one
         S_SHIFT: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            if (up_ff) begin
               ram_waddr = addr_ff + ADDR_ONE;
               if (addr_ff == pos_ff) begin
                  state_in = S_PLACE;
               end else begin
                  ram_raddr = addr_ff - ADDR_ONE;
                  addr_in   = addr_ff - ADDR_ONE;
               end
            end else begin
               ram_waddr = addr_ff - ADDR_ONE;
               if (addr_ff == last_addr) begin
                  count_in = count_ff - CNT_ONE;
                  state_in = S_DONE;
               end else begin
                  ram_raddr = addr_ff + ADDR_ONE;
                  addr_in   = addr_ff + ADDR_ONE;
               end
            end
         end

         S_PLACE: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = val_ff;
            count_in  = count_ff + CNT_ONE;
            state_in  = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               done_valid = 1'b1;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign done_result.read_data = rd_ff;
   assign done_result.length    = LEN_BITS'(count_ff);
   assign done_result.status    = status_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Operation payload
   always_ff @(posedge clock) begin
      up_ff     <= up_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      addr_ff   <= addr_in;
      rd_ff     <= rd_in;
      status_ff <= status_in;
   end

endmodule

// ===== rtl/core/ple_rsp_stage.sv =====
// ple_rsp_stage: output register for the response channel; holds a finished
// word while the sequencer goes on. Depends on ple_pkg, ple_if.
module ple_rsp_stage import ple_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       done_valid,
   input  result_type done_result,
   output logic       out_free,
   ple_rsp_if.source  rsp_if
);

   logic       valid_ff, valid_in;
   result_type word_ff, word_in;

   assign out_free = !valid_ff || rsp_if.ready;

   // Load a new word when one arrives, drop the old one once taken
   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (done_valid) begin
         valid_in = 1'b1;
         word_in  = done_result;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_if.valid     = valid_ff;
   assign rsp_if.read_data = word_ff.read_data;
   assign rsp_if.length    = word_ff.length;
   assign rsp_if.status    = word_ff.status;

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// positional_list_engine: top level of the indexed list store.
// Depends on ple_pkg, ple_if, ple_ram, ple_ctrl, ple_rsp_stage.
//
// Holds an ordered list of up to DEPTH handles in one simple dual-port RAM
// and answers one request word at a time with one response word. A read adds
// an S_READ step for the registered RAM read. Insert moves
// (count - position) entries and then writes the new one; delete moves
// (count - 1 - position). Inserting at the end or deleting the last entry
// costs the same as append. Each moved entry is one write on the RAM's
// single write port, which sets the cost of insert and delete. The response
// sits in an output register, so a new request is taken while the last
// response waits. Positions above 127 are not addressable.
module positional_list_engine import ple_pkg::*; #(
   parameter int unsigned DEPTH      = 64,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   ple_req_if.sink   req_if,
   ple_rsp_if.source rsp_if
);

   localparam int unsigned AW = $clog2(DEPTH);

   logic                  out_free;
   logic                  done_valid;
   result_type            done_result;
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [VALUE_BITS-1:0] ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [VALUE_BITS-1:0] ram_rdata;

   ple_ctrl #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .out_free    (out_free),
      .done_valid  (done_valid),
      .done_result (done_result),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata)
   );

   // Entry store
   ple_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ple_rsp_stage u_rsp_stage (
      .clock       (clock),
      .reset       (reset),
      .done_valid  (done_valid),
      .done_result (done_result),
      .out_free    (out_free),
      .rsp_if      (rsp_if)
   );

endmodule

// ===== rtl/core/ple_checker.sv =====
// ple_checker: port-level assertions for positional_list_engine, and the bind
// that attaches them. Depends on ple_pkg.
module ple_checker import ple_pkg::*; #(
   parameter int unsigned DEPTH = 64
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [DATA_BITS-1:0] rsp_read_data,
   input logic [LEN_BITS-1:0]  rsp_length,
   input status_type           rsp_status
);

   // No response word survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // One word at a time: ready drops after every accepted request
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready held after acceptance");

   // A refused request never returns data
   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_read_data == '0))
      else $error("data returned with a failure status");

   // Length never exceeds the store size
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((DEPTH > 127) || (32'(rsp_length) <= DEPTH)))
      else $error("length beyond store depth");

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_read_data) && $stable(rsp_length)
          && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_read_data (rsp_if.read_data),
   .rsp_length    (rsp_if.length),
   .rsp_status    (rsp_if.status)
);

// ===== test/testbench.sv =====
// testbench: self-checking regression for positional_list_engine.
// Depends on ple_pkg and the ple_req_if / ple_rsp_if channel interfaces.
// A shadow list predicts every response word; checks compare field by field.
module testbench;
   import ple_pkg::*;

   localparam int LIST_DEPTH   = 64;
   localparam int RANDOM_WORDS = 1625;
   localparam int TAIL_CYCLES  = 80;
   // Command codes 5 to 7 are unused and must be refused
   localparam logic [CMD_BITS-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [CMD_BITS-1:0]  command;
      logic [POS_BITS-1:0]  position;
      logic [DATA_BITS-1:0] element;
   } request_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ple_req_if req_ch ();
   ple_rsp_if rsp_ch ();

   positional_list_engine #(
      .DEPTH      (LIST_DEPTH),
      .VALUE_BITS (DATA_BITS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Request words waiting to go out, and responses the shadow list expects
   request_word_type outgoing_words[$];
   result_type       expected_rsps[$];

   // Shadow copy of the list contents
   logic [DATA_BITS-1:0] shadow_entries[LIST_DEPTH];
   int unsigned          shadow_length = 0;

   int words_sent    = 0;
   int error_count   = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // Stimulus side only tracks the length, which decides every status code
   int planned_length = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Apply one list operation to the shadow list and return its response word
   function automatic result_type apply_list_op(input logic [CMD_BITS-1:0] cmd,
                                                input logic [POS_BITS-1:0] pos,
                                                input logic [DATA_BITS-1:0] elem);
      result_type  rsp;
      int unsigned idx;
      rsp.read_data = '0;
      rsp.status    = ST_OK;
      case (cmd)
         CMD_READ: begin
            if (shadow_length == 0) rsp.status = ST_EMPTY;
            else if (pos >= shadow_length) rsp.status = ST_RANGE;
            else rsp.read_data = shadow_entries[pos];
         end
         CMD_INSERT: begin
            if (shadow_length >= LIST_DEPTH) rsp.status = ST_FULL;
            else if (pos > shadow_length) rsp.status = ST_RANGE;
            else begin
               for (idx = shadow_length; idx > pos; idx--)
                  shadow_entries[idx] = shadow_entries[idx-1];
               shadow_entries[pos] = elem;
               shadow_length++;
            end
         end
         CMD_APPEND: begin
            if (shadow_length >= LIST_DEPTH) rsp.status = ST_FULL;
            else begin
               shadow_entries[shadow_length] = elem;
               shadow_length++;
            end
         end
         CMD_DELETE: begin
            if (shadow_length == 0) rsp.status = ST_EMPTY;
            else if (pos >= shadow_length) rsp.status = ST_RANGE;
            else begin
               for (idx = pos; idx + 1 < shadow_length; idx++)
                  shadow_entries[idx] = shadow_entries[idx+1];
               shadow_length--;
            end
         end
         CMD_MODIFY: begin
            if (shadow_length == 0) rsp.status = ST_EMPTY;
            else if (pos >= shadow_length) rsp.status = ST_RANGE;
            else shadow_entries[pos] = elem;
         end
         default: rsp.status = ST_RANGE;
      endcase
      rsp.length = shadow_length[LEN_BITS-1:0];
      return rsp;
   endfunction

   // Queue a request word and follow the list length it leaves behind
   task automatic queue_word(input logic [CMD_BITS-1:0] cmd, input int pos,
                             input logic [DATA_BITS-1:0] elem);
      request_word_type w;
      w.command  = cmd;
      w.position = pos[POS_BITS-1:0];
      w.element  = elem;
      outgoing_words.push_back(w);
      case (cmd)
         CMD_INSERT: if (planned_length < LIST_DEPTH && pos <= planned_length)
                        planned_length++;
         CMD_APPEND: if (planned_length < LIST_DEPTH) planned_length++;
         CMD_DELETE: if (planned_length > 0 && pos < planned_length) planned_length--;
         default: ;
      endcase
   endtask

   // Request driver: holds a word until taken, idles at random between words
   always @(posedge clock) begin : drive_requests
      logic stalled;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            void'(outgoing_words.pop_front());
            words_sent++;
         end
         stalled = req_ch.valid && !req_ch.ready;
         if (!stalled) begin
            if (outgoing_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid    <= 1'b1;
               req_ch.command  <= outgoing_words[0].command;
               req_ch.position <= outgoing_words[0].position;
               req_ch.element  <= outgoing_words[0].element;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response word first, then predicts the word accepted
   // at this edge, so ordering inside the time step never matters
   always @(posedge clock) begin : watch_channels
      result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               flag_error("response word with nothing outstanding");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_ch.read_data !== want.read_data)
                  flag_error($sformatf("read_data got %h expected %h",
                                       rsp_ch.read_data, want.read_data));
               if (rsp_ch.length !== want.length)
                  flag_error($sformatf("length got %0d expected %0d",
                                       rsp_ch.length, want.length));
               if (rsp_ch.status !== want.status)
                  flag_error($sformatf("status got %0d expected %0d",
                                       rsp_ch.status, want.status));
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_rsps.push_back(apply_list_op(req_ch.command, req_ch.position,
                                                  req_ch.element));
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Stimulus, idle phases and end of run
   initial begin : run_regression
      int                   n;
      int                   roll;
      int                   pos;
      int                   total_words;
      logic                 growing;
      logic [CMD_BITS-1:0]  cmd;
      logic [DATA_BITS-1:0] elem;

      // Directed: empty store, unused codes, insert at front/middle/end,
      // range edges, modify, delete in the middle, at the end and at the front
      queue_word(CMD_READ,   0, '0);
      queue_word(CMD_DELETE, 0, '0);
      queue_word(CMD_MODIFY, 0, 32'h1111_1111);
      queue_word(CMD_INSERT, 1, 32'h2222_2222);
      queue_word(CMD_SPARE_FIRST, 127, 32'hFFFF_FFFF);
      queue_word(CMD_SPARE_LAST,  0, '0);
      queue_word(CMD_INSERT, 0, 32'h0000_0000);
      queue_word(CMD_APPEND, 127, 32'hFFFF_FFFF);
      queue_word(CMD_INSERT, 1, 32'h1234_5678);
      queue_word(CMD_INSERT, 3, 32'h8000_0001);
      queue_word(CMD_INSERT, 5, 32'h7FFF_FFFE);
      for (n = 0; n < 4; n++) queue_word(CMD_READ, n, '0);
      queue_word(CMD_READ,   4, '0);
      queue_word(CMD_READ,   127, '0);
      queue_word(CMD_MODIFY, 2, 32'hA5A5_A5A5);
      queue_word(CMD_MODIFY, 4, 32'h5A5A_5A5A);
      queue_word(CMD_READ,   2, '0);
      queue_word(CMD_DELETE, 1, '0);
      queue_word(CMD_DELETE, 2, '0);
      queue_word(CMD_DELETE, 0, '0);
      queue_word(CMD_DELETE, 5, '0);
      queue_word(CMD_READ,   0, '0);

      // Random: the list swings between empty and full, lingering at the ends
      growing = 1'b1;
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (planned_length == LIST_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
         if (planned_length == 0 && $urandom_range(3) == 0) growing = 1'b1;
         roll = $urandom_range(99);
         if (roll < 4)
            cmd = CMD_BITS'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
         else if (roll < 22) cmd = CMD_READ;
         else if (roll < 32) cmd = CMD_MODIFY;
         else if (growing)
            cmd = (roll < 72) ? CMD_INSERT : ((roll < 90) ? CMD_APPEND : CMD_DELETE);
         else
            cmd = (roll < 80) ? CMD_DELETE : ((roll < 90) ? CMD_INSERT : CMD_APPEND);

         roll = $urandom_range(99);
         if (roll < 70) begin
            if (cmd == CMD_INSERT) pos = $urandom_range(planned_length);
            else pos = (planned_length == 0) ? 0 : $urandom_range(planned_length - 1);
         end else if (roll < 80) pos = planned_length;
         else if (roll < 88)     pos = 0;
         else                    pos = $urandom_range(127);

         roll = $urandom_range(99);
         if (roll < 10)      elem = '0;
         else if (roll < 20) elem = '1;
         else                elem = $urandom;
         queue_word(cmd, pos, elem);
      end
      total_words = outgoing_words.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Busy sender and heavily stalled receiver, then swapped, then no idling
      send_idle_pct = 31;
      rsp_stall_pct = 84;
      while (words_sent < total_words / 3) @(negedge clock);
      send_idle_pct = 84;
      rsp_stall_pct = 31;
      while (words_sent < (2 * total_words) / 3) @(negedge clock);
      send_idle_pct = 0;
      rsp_stall_pct = 0;

      while (outgoing_words.size() != 0 || expected_rsps.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("positional_list_engine regression: pass");
      end else begin
         $display("positional_list_engine regression: fail");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin : watchdog
      #10_000_000;
      $display("positional_list_engine regression: fail");
      $finish;
   end

endmodule

// ===== positional_list_engine.f =====
rtl/core/ple_pkg.sv
rtl/core/ple_if.sv
rtl/core/ple_ram.sv
rtl/core/ple_ctrl.sv
rtl/core/ple_rsp_stage.sv
rtl/core/positional_list_engine.sv
rtl/core/ple_checker.sv
test/testbench.sv
